// ===== sv/hbs_pkg.sv =====
// package for the histogram engine: item kinds, command and status structs
// no dependencies
package hbs_pkg;

  // fixed sizes of the engine
  localparam int MAX_BINS    = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 32;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_WEIGHT = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_REPORT = 2'd3
  } kind_t;

  localparam logic [1:0] REG_BIN_COUNT = 2'd0;
  localparam logic [1:0] REG_LOWER     = 2'd1;
  localparam logic [1:0] REG_UPPER     = 2'd2;
  localparam logic [1:0] REG_OUTLIERS  = 2'd3;

  localparam int TOTAL_BITS = 40;
  localparam int CS_BITS    = 51;
  localparam int SQ_BITS    = 59;
  localparam int POS_BITS   = 53;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture input word
    logic div_start;  // start bin divider
    logic upd_read;   // issue store read for update
    logic upd_write;  // write updated count
    logic upd_weight; // update uses the named bin and weight
    logic clr_start;  // reset sweep pointer
    logic clr_write;  // clear one entry
    logic rep_start;  // reset report accumulators
    logic rep_read;   // issue report read
    logic rep_done;   // form result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_busy;
    logic need_div;   // sample falls in the divided span
    logic idx_ok;     // weight index in range
    logic clr_last;
    logic rep_last;
    logic acc_busy;
  } stat_t;

endpackage

// ===== sv/hbs_ctrl.sv =====
// controller state machine for the histogram engine
// depends on hbs_pkg
module hbs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          kind,
  output logic                out_valid,
  input  logic                out_ready,
  input  hbs_pkg::stat_t      stat,
  output hbs_pkg::cmd_t       cmd
);
  import hbs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_DIV, S_RD, S_WR, S_CLR, S_RSTART, S_RRD, S_RDRAIN, S_RFIN, S_OUT
  } state_t;

  state_t state;
  logic [1:0] kind_q;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    case (state)
      S_DECODE: begin
        if (kind_q == KIND_SAMPLE && stat.need_div) cmd.div_start = 1'b1;
        if (kind_q == KIND_CLEAR) cmd.clr_start = 1'b1;
        if (kind_q == KIND_REPORT) cmd.rep_start = 1'b1;
      end
      S_RD:     begin
        cmd.upd_read = 1'b1;
        cmd.upd_weight = (kind_q == KIND_WEIGHT);
      end
      S_WR:     begin
        cmd.upd_write = 1'b1;
        cmd.upd_weight = (kind_q == KIND_WEIGHT);
      end
      S_CLR:    cmd.clr_write = 1'b1;
      S_RRD:    cmd.rep_read = 1'b1;
      S_RFIN:   cmd.rep_done = !stat.acc_busy;
      default:  ;
    endcase
  end

  // state register; reset starts with a sweep that zeroes the store
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      kind_q <= KIND_SAMPLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          kind_q <= kind;
          state <= S_DECODE;
        end
        S_DECODE: case (kind_q)
          KIND_SAMPLE: state <= stat.need_div ? S_DIV : S_RD;
          KIND_WEIGHT: state <= stat.idx_ok ? S_RD : S_IDLE;
          KIND_CLEAR:  state <= S_CLR;
          default:     state <= S_RRD;
        endcase
        S_DIV:    if (!stat.div_busy) state <= S_RD;
        S_RD:     state <= S_WR;
        S_WR:     state <= S_IDLE;
        S_CLR:    if (stat.clr_last) state <= S_IDLE;
        S_RRD:    if (stat.rep_last) state <= S_RDRAIN;
        S_RDRAIN: state <= S_RFIN;
        S_RFIN:   if (!stat.acc_busy) begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT:    if (out_ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default:  state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/hbs_div.sv =====
// restoring divider, one quotient bit per cycle
// no package dependencies
module hbs_div #(
  parameter int NUM_BITS = 25,
  parameter int DEN_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                busy,
  output logic [NUM_BITS-1:0] quo
);
  localparam int CW = $clog2(NUM_BITS + 1);

  logic [CW-1:0]       cnt;
  logic [DEN_BITS:0]   rem;
  logic [NUM_BITS-1:0] nq;
  logic [DEN_BITS:0]   trial;

  assign trial = {rem[DEN_BITS-1:0], nq[NUM_BITS-1]};
  assign quo = nq;

  // shift and subtract
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CW'(NUM_BITS);
      rem <= '0;
      nq <= num;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        nq <= {nq[NUM_BITS-2:0], 1'b1};
      end else begin
        rem <= trial;
        nq <= {nq[NUM_BITS-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end
endmodule

// ===== sv/hbs_dp.sv =====
// datapath: config registers, bin store, binning, update and report accumulators
// depends on hbs_pkg and hbs_div
module hbs_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [1:0]                    cfg_index,
  input  logic [31:0]                   cfg_data,
  input  hbs_pkg::cmd_t                 cmd,
  output hbs_pkg::stat_t                stat,
  input  logic [hbs_pkg::SAMPLE_BITS-1:0] sample_value,
  input  logic [8:0]                    bin_index,
  input  logic [31:0]                   weight,
  output logic                          empty_res,
  output logic [8:0]                    first_bin,
  output logic [8:0]                    last_bin,
  output logic [31:0]                   max_count,
  output logic [31:0]                   min_count,
  output logic [hbs_pkg::TOTAL_BITS-1:0] total_count,
  output logic signed [hbs_pkg::CS_BITS-1:0] centre_sum,
  output logic [hbs_pkg::SQ_BITS-1:0]   centre_square_sum
);
  import hbs_pkg::*;

  localparam int DEPTH = MAX_BINS + 2;
  localparam int AW = $clog2(DEPTH);
  localparam int NB = 9;
  localparam int NUMW = 16 + NB;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic [TOTAL_BITS-1:0] TCAP = '1;
  localparam logic [SQ_BITS-1:0]   SCAP = '1;
  localparam logic [POS_BITS-1:0]  PCAP = {1'b1, {(POS_BITS-1){1'b0}}};

  // configuration registers
  logic [8:0]  bin_count;
  logic [15:0] lower_bound, upper_bound;
  logic        count_outliers;
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count <= 9'd1;
      lower_bound <= '0;
      upper_bound <= 16'hFFFF;
      count_outliers <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BIN_COUNT: bin_count <= cfg_data[8:0];
        REG_LOWER:     lower_bound <= cfg_data[15:0];
        REG_UPPER:     upper_bound <= cfg_data[15:0];
        REG_OUTLIERS:  count_outliers <= cfg_data[0];
        default:       bin_count <= bin_count;
      endcase
    end
  end

  logic [NB:0] n;
  always_comb begin
    if (bin_count == 9'd0) n = 10'd1;
    else if (10'(bin_count) > 10'(MAX_BINS)) n = 10'(MAX_BINS);
    else n = {1'b0, bin_count};
  end

  // captured input word
  logic [15:0] v;
  logic [8:0]  idx_q;
  logic [31:0] w_q;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v <= 16'(sample_value);
      idx_q <= bin_index;
      w_q <= weight;
    end
  end

  // direct bin rules
  logic [NB:0] direct_bin;
  logic        need_div;
  always_comb begin
    need_div = 1'b0;
    direct_bin = '0;
    if (v < lower_bound) direct_bin = '0;
    else if (v == upper_bound) direct_bin = n;
    else if (v > upper_bound) direct_bin = n + 1'b1;
    else need_div = 1'b1;
  end

  logic [15:0] span;
  logic [NUMW-1:0] num;
  logic [NUMW-1:0] quo;
  logic div_busy;
  assign span = upper_bound - lower_bound;
  assign num = NUMW'(v - lower_bound) * NUMW'(n);

  hbs_div #(.NUM_BITS(NUMW), .DEN_BITS(16)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(num), .den(span),
    .busy(div_busy), .quo(quo)
  );

  logic div_used;
  always_ff @(posedge clk) begin
    if (cmd.load) div_used <= 1'b0;
    else if (cmd.div_start) div_used <= 1'b1;
  end

  logic [AW-1:0] upd_addr;
  logic [31:0]   upd_amt;
  always_comb begin
    if (div_used) upd_addr = AW'(quo + 1'b1);
    else if (need_div) upd_addr = '0;
    else upd_addr = AW'(direct_bin);
    upd_amt = 32'd1;
    if (cmd.upd_weight) begin
      upd_addr = AW'(idx_q);
      upd_amt = w_q;
    end
  end

  assign stat.div_busy = div_busy;
  assign stat.need_div = need_div;
  assign stat.idx_ok = {1'b0, idx_q} <= n + 1'b1;

  // bin store
  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rdata;
  logic [AW-1:0] ptr, rd_addr, wr_addr;
  logic [COUNT_BITS-1:0] wdata;
  logic wen;
  logic [AW:0] first_i, last_i;

  assign first_i = count_outliers ? '0 : (AW+1)'(1);
  assign last_i  = count_outliers ? (AW+1)'(n + 1'b1) : (AW+1)'(n);

  logic [COUNT_BITS:0] sum;
  assign sum = {1'b0, rdata} + {1'b0, COUNT_BITS'(upd_amt)};
  always_comb begin
    wen = cmd.upd_write || cmd.clr_write;
    wr_addr = cmd.clr_write ? ptr : upd_addr;
    wdata = cmd.clr_write ? '0 : (sum[COUNT_BITS] ? CMAX : sum[COUNT_BITS-1:0]);
    rd_addr = cmd.rep_read ? ptr : upd_addr;
  end
  always_ff @(posedge clk) begin
    if (wen) mem[wr_addr] <= wdata;
    if (cmd.upd_read || cmd.rep_read) rdata <= mem[rd_addr];
  end

  assign stat.clr_last = (ptr == AW'(DEPTH - 1));
  assign stat.rep_last = ({1'b0, ptr} == last_i);

  // sweep pointer
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) ptr <= '0;
    else if (cmd.rep_start) ptr <= first_i[AW-1:0];
    else if (cmd.clr_write || cmd.rep_read) ptr <= ptr + 1'b1;
  end

  // report pipeline: read, multiply, accumulate
  logic          s1_v, s2_v;
  logic [AW-1:0] s1_i, s2_i;
  logic [COUNT_BITS-1:0] s2_c;
  logic [NB+1:0] ctr;
  logic [2*NB+3:0] ctr2;
  logic [COUNT_BITS+NB+1:0] p1;
  assign ctr = (NB+2)'({s1_i, 1'b0} - 1'b1);
  always_ff @(posedge clk) begin
    if (rst || cmd.rep_start) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= cmd.rep_read;
      s2_v <= s1_v;
    end
    s1_i <= ptr;
    s2_i <= s1_i;
    s2_c <= rdata;
    p1 <= (COUNT_BITS+NB+2)'(rdata) * (COUNT_BITS+NB+2)'(ctr);
    ctr2 <= (2*NB+4)'(ctr) * (2*NB+4)'(ctr);
  end

  logic [COUNT_BITS+2*NB+3:0] psq;
  logic s3_v;
  logic [AW-1:0] s3_i;
  logic [COUNT_BITS-1:0] s3_c;
  logic [COUNT_BITS+NB+1:0] s3_p;
  always_ff @(posedge clk) begin
    if (rst || cmd.rep_start) s3_v <= 1'b0;
    else s3_v <= s2_v;
    s3_i <= s2_i;
    s3_c <= s2_c;
    s3_p <= p1;
    psq <= (COUNT_BITS+2*NB+4)'(s2_c) * (COUNT_BITS+2*NB+4)'(ctr2);
  end
  assign stat.acc_busy = s1_v || s2_v || s3_v;

  logic any;
  logic [8:0] fnz, lnz;
  logic [COUNT_BITS-1:0] mx, mn, neg;
  logic [TOTAL_BITS-1:0] tot;
  logic [POS_BITS-1:0] pos;
  logic [SQ_BITS-1:0] sq;
  logic [TOTAL_BITS:0] tot_s;
  logic [POS_BITS:0] pos_s, pterm;
  logic [SQ_BITS:0] sq_s, sterm;
  always_comb begin
    tot_s = {1'b0, tot} + (TOTAL_BITS+1)'(s3_c);
    pterm = ((POS_BITS+1)'(s3_p) > {1'b0, PCAP}) ? {1'b0, PCAP} : (POS_BITS+1)'(s3_p);
    pos_s = {1'b0, pos} + pterm;
    sterm = (s3_i == '0) ? (SQ_BITS+1)'(s3_c) :
            ((psq > (COUNT_BITS+2*NB+4)'(SCAP)) ? {1'b0, SCAP} : (SQ_BITS+1)'(psq));
    sq_s = {1'b0, sq} + sterm;
  end
  always_ff @(posedge clk) begin
    if (cmd.rep_start) begin
      any <= 1'b0; fnz <= '0; lnz <= '0; mx <= '0; mn <= CMAX; neg <= '0;
      tot <= '0; pos <= '0; sq <= '0;
    end else if (s3_v) begin
      if (s3_c != '0) begin
        if (!any) fnz <= 9'(s3_i);
        lnz <= 9'(s3_i);
        any <= 1'b1;
      end
      if (s3_c > mx) mx <= s3_c;
      if (s3_c < mn) mn <= s3_c;
      tot <= tot_s[TOTAL_BITS] ? TCAP : tot_s[TOTAL_BITS-1:0];
      if (s3_i == '0) neg <= s3_c;
      else pos <= (pos_s > {1'b0, PCAP}) ? PCAP : pos_s[POS_BITS-1:0];
      sq <= sq_s[SQ_BITS] ? SCAP : sq_s[SQ_BITS-1:0];
    end
  end

  // result registers
  logic signed [POS_BITS:0] cs;
  localparam logic signed [POS_BITS:0] CSHI = (POS_BITS+1)'((64'd1 << (CS_BITS-1)) - 1);
  assign cs = $signed({1'b0, pos}) - $signed((POS_BITS+1)'(neg));
  always_ff @(posedge clk) begin
    if (cmd.rep_done) begin
      empty_res <= !any;
      first_bin <= any ? fnz : '0;
      last_bin <= any ? lnz : '0;
      max_count <= any ? 32'(mx) : '0;
      min_count <= any ? 32'(mn) : '0;
      total_count <= any ? tot : '0;
      if (!any) centre_sum <= '0;
      else if (cs > CSHI) centre_sum <= CS_BITS'(CSHI);
      else if (cs < -CSHI - 1) centre_sum <= CS_BITS'(-CSHI - 1);
      else centre_sum <= CS_BITS'(cs);
      centre_square_sum <= any ? sq : '0;
    end
  end
endmodule

// ===== sv/histogram_bin_and_statistics.sv =====
// top level of the histogram engine: sample, weight, clear and report words
// a sample is decoded, optionally binned by the divider (one bit per cycle), then read and
// written; a weight is read and written, or dropped when the index is out of range; a clear
// walks the whole store; a report reads the counted bins, drains the pipeline and then holds
// the result until taken; one word at a time. synchronous reset clears control and config,
// then a sweep zeroes the store while input is held off
module histogram_bin_and_statistics (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] sample_value,
  input  logic [8:0]  bin_index,
  input  logic [31:0] weight,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        empty_res,
  output logic [8:0]  first_bin,
  output logic [8:0]  last_bin,
  output logic [31:0] max_count,
  output logic [31:0] min_count,
  output logic [39:0] total_count,
  output logic signed [50:0] centre_sum,
  output logic [58:0] centre_square_sum
);
  import hbs_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  assign cfg_ready = 1'b1;

  hbs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  hbs_dp u_dp (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cmd(cmd), .stat(stat), .sample_value(sample_value),
    .bin_index(bin_index), .weight(weight), .empty_res(empty_res),
    .first_bin(first_bin), .last_bin(last_bin), .max_count(max_count),
    .min_count(min_count), .total_count(total_count), .centre_sum(centre_sum),
    .centre_square_sum(centre_square_sum)
  );
endmodule
